/* src/tslot_pkg.sv */
// -----------------------------------------------------------------------------
// tslot_pkg
// Shared types, codes and defaults for the timer slot block.
// -----------------------------------------------------------------------------
package tslot_pkg;

	localparam int DEF_SLOT_COUNT   = 16;
	localparam int DEF_HANDLER_BITS = 8;

	localparam int OP_W     = 2;
	localparam int PERIOD_W = 32;
	localparam int HID_W    = 8;
	localparam int SLOT_W   = 4;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_PER  = 2'd0,
		OP_ADD_ONE  = 2'd1,
		OP_TICK_PER = 2'd2,
		OP_TICK_ONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // latch the input item, rewind the slot index
		logic take;    // claim the slot under the index for an add
		logic read;    // fetch the slot under the index
		logic commit;  // write back the fetched slot after the tick
		logic step;    // advance the slot index
		logic emit;    // send the closing result of the item
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_add;
		logic slot_active;
		logic idx_last;
		logic commit_ok;
		logic out_free;
	} sts_t;

endpackage

/* src/tslot_ram.sv */
// -----------------------------------------------------------------------------
// tslot_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module tslot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/tslot_ctrl.sv */
// -----------------------------------------------------------------------------
// tslot_ctrl
// Sequencer: walks the slots of one bank for each item, one step at a time.
// -----------------------------------------------------------------------------
module tslot_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tslot_pkg::sts_t sts,
	output tslot_pkg::cmd_t cmd
);

	import tslot_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.is_add) begin
					if (!sts.slot_active || sts.idx_last) state_d = ST_DONE;
				end else if (sts.slot_active) begin
					state_d = ST_EVAL;
				end else if (sts.idx_last) begin
					state_d = ST_DONE;
				end
			end
			ST_EVAL: begin
				if (sts.commit_ok) state_d = sts.idx_last ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				if (sts.is_add) begin
					cmd.take = !sts.slot_active;
					cmd.step = sts.slot_active && !sts.idx_last;
				end else begin
					cmd.read = sts.slot_active;
					cmd.step = !sts.slot_active && !sts.idx_last;
				end
			end
			ST_EVAL: begin
				cmd.commit = sts.commit_ok;
				cmd.step   = sts.commit_ok && !sts.idx_last;
			end
			ST_DONE: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.take, cmd.read, cmd.commit, cmd.emit}))
		else $error("tslot_ctrl: more than one slot command at once");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SCAN))
		else $error("tslot_ctrl: accepted item did not start a scan");

	a_emit_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == ST_IDLE && in_ready))
		else $error("tslot_ctrl: closing result did not return to idle");

endmodule

/* src/tslot_dp.sv */
// -----------------------------------------------------------------------------
// tslot_dp
// Slot storage, active flags, tick arithmetic and result registers.
// -----------------------------------------------------------------------------
module tslot_dp #(
	parameter int SLOT_COUNT   = tslot_pkg::DEF_SLOT_COUNT,
	parameter int HANDLER_BITS = tslot_pkg::DEF_HANDLER_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tslot_pkg::cmd_t                    cmd,
	output tslot_pkg::sts_t                    sts,
	input  logic [tslot_pkg::OP_W-1:0]         operation,
	input  logic [tslot_pkg::PERIOD_W-1:0]     period,
	input  logic [tslot_pkg::HID_W-1:0]        handler_id,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               accepted,
	output logic                               fired,
	output logic [tslot_pkg::SLOT_W-1:0]       slot,
	output logic [tslot_pkg::HID_W-1:0]        fired_handler,
	output logic                               last
);

	import tslot_pkg::*;

	localparam int SlotW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int RamDepth = 2 * (2 ** SlotW);
	localparam int RamW     = 2 * PERIOD_W + HANDLER_BITS;

	// latched item
	op_t                       op_q;
	logic [PERIOD_W-1:0]       period_q;
	logic [HANDLER_BITS-1:0]   hid_q;
	logic [SlotW-1:0]          idx_q;

	logic [SLOT_COUNT-1:0]     act_per_q;
	logic [SLOT_COUNT-1:0]     act_one_q;

	// result waiting for the next firing or the end of the walk
	logic                      pend_valid_q;
	logic                      pend_acc_q;
	logic                      pend_fired_q;
	logic [SlotW-1:0]          pend_slot_q;
	logic [HANDLER_BITS-1:0]   pend_hnd_q;

	logic                      out_valid_q;
	logic                      out_acc_q;
	logic                      out_fired_q;
	logic [SLOT_W-1:0]         out_slot_q;
	logic [HID_W-1:0]          out_hnd_q;
	logic                      out_last_q;

	logic                      is_add;
	logic                      bank_one;
	logic                      slot_active;
	logic                      out_free;
	logic                      fire;
	logic                      push_mid;
	logic [PERIOD_W-1:0]       rd_count;
	logic [PERIOD_W-1:0]       rd_limit;
	logic [HANDLER_BITS-1:0]   rd_hnd;
	logic [PERIOD_W-1:0]       cnt_inc;

	logic                      ram_we;
	logic [SlotW:0]            ram_addr;
	logic [RamW-1:0]           ram_wdata;
	logic [RamW-1:0]           ram_rdata;

	assign is_add      = (op_q == OP_ADD_PER) || (op_q == OP_ADD_ONE);
	assign bank_one    = (op_q == OP_ADD_ONE) || (op_q == OP_TICK_ONE);
	assign slot_active = bank_one ? act_one_q[idx_q] : act_per_q[idx_q];
	assign out_free    = !out_valid_q || out_ready;

	assign rd_count = ram_rdata[RamW-1 -: PERIOD_W];
	assign rd_limit = ram_rdata[HANDLER_BITS +: PERIOD_W];
	assign rd_hnd   = ram_rdata[HANDLER_BITS-1:0];
	assign cnt_inc  = rd_count + PERIOD_W'(1);
	assign fire     = cnt_inc > rd_limit;
	assign push_mid = cmd.commit && fire && pend_valid_q;

	assign ram_addr = {bank_one, idx_q};
	assign ram_we   = cmd.take || cmd.commit;

	always_comb begin
		if (cmd.take) begin
			ram_wdata = {PERIOD_W'(0), period_q - PERIOD_W'(1), hid_q};
		end else begin
			ram_wdata = {(fire ? PERIOD_W'(0) : cnt_inc), rd_limit, rd_hnd};
		end
	end

	tslot_ram #(
		.WIDTH (RamW),
		.DEPTH (RamDepth)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (cmd.read),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.is_add      = is_add;
		sts.slot_active = slot_active;
		sts.idx_last    = (idx_q == SlotW'(SLOT_COUNT - 1));
		sts.commit_ok   = !(fire && pend_valid_q) || out_free;
		sts.out_free    = out_free;
	end

	// item fields and slot index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(operation);
			period_q <= period;
			hid_q    <= HANDLER_BITS'(handler_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + SlotW'(1);
		end
	end

	// active flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_per_q <= '0;
			act_one_q <= '0;
		end else if (cmd.take) begin
			if (bank_one) act_one_q[idx_q] <= 1'b1;
			else          act_per_q[idx_q] <= 1'b1;
		end else if (cmd.commit && fire && bank_one) begin
			act_one_q[idx_q] <= 1'b0;
		end
	end

	// pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.take || (cmd.commit && fire)) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.emit) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_acc_q   <= 1'b1;
			pend_fired_q <= 1'b0;
			pend_slot_q  <= idx_q;
			pend_hnd_q   <= '0;
		end else if (cmd.commit && fire) begin
			pend_acc_q   <= 1'b0;
			pend_fired_q <= 1'b1;
			pend_slot_q  <= idx_q;
			pend_hnd_q   <= rd_hnd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_mid || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || cmd.emit) begin
			out_acc_q   <= pend_valid_q && pend_acc_q;
			out_fired_q <= pend_valid_q && pend_fired_q;
			out_slot_q  <= pend_valid_q ? SLOT_W'(pend_slot_q) : '0;
			out_hnd_q   <= pend_valid_q ? HID_W'(pend_hnd_q) : '0;
			out_last_q  <= cmd.emit;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = out_acc_q;
	assign fired         = out_fired_q;
	assign slot          = out_slot_q;
	assign fired_handler = out_hnd_q;
	assign last          = out_last_q;

	a_push_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push_mid || cmd.emit) |-> out_free)
		else $error("tslot_dp: result pushed over one not yet taken");

	a_take_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (slot_active && pend_valid_q && pend_acc_q))
		else $error("tslot_dp: add did not claim its slot");

endmodule

/* src/periodic_and_one_shot_timer_slots.sv */
// -----------------------------------------------------------------------------
// periodic_and_one_shot_timer_slots
// Two banks of timer slots (periodic and one-shot) with add and tick requests.
// -----------------------------------------------------------------------------
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ----------------------------------
// in       to block   in_valid / in_ready  operation, period, handler_id
// out      from block out_valid/out_ready  accepted, fired, slot,
//                                          fired_handler, last
//
// one item at a time; an add walks the occupied slots ahead of the free one
// (the whole bank when it is full), and a tick scans every slot of its bank
// and fetches and evaluates each active one; the walk sets the item's length:
// each active slot needs a read of the shared slot ram and a write back of
// its count
// reset clears the active flags, not the slot contents; slot contents are
// written by the add that activates a slot, so no clearing pass runs
// a stalled out channel holds the walk at any firing after the first, or at the end
//
module periodic_and_one_shot_timer_slots #(
	parameter int SLOT_COUNT   = tslot_pkg::DEF_SLOT_COUNT,
	parameter int HANDLER_BITS = tslot_pkg::DEF_HANDLER_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [tslot_pkg::OP_W-1:0]     operation,
	input  logic [tslot_pkg::PERIOD_W-1:0] period,
	input  logic [tslot_pkg::HID_W-1:0]    handler_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic                           fired,
	output logic [tslot_pkg::SLOT_W-1:0]   slot,
	output logic [tslot_pkg::HID_W-1:0]    fired_handler,
	output logic                           last
);

	import tslot_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: idle, scan a slot, evaluate a fetched slot, close the item
	tslot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: slot ram, active flags, count update, pending and out registers
	tslot_dp #(
		.SLOT_COUNT   (SLOT_COUNT),
		.HANDLER_BITS (HANDLER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.period        (period),
		.handler_id    (handler_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.fired         (fired),
		.slot          (slot),
		.fired_handler (fired_handler),
		.last          (last)
	);

endmodule
